[rtl/vef_pkg.sv]
// ----------------------------------------------------------------------------
// vef_pkg: shared types, constants and helpers of the vertical emboss filter
//
// Holds the pixel and result types, the field widths, the register indexes
// and the per-channel emboss function.
// ----------------------------------------------------------------------------
package vef_pkg;

   localparam int CHAN_W        = 8;
   localparam int RGB_W         = 3 * CHAN_W;
   localparam int ROW_W         = 12;
   localparam int COL_OUT_W     = 9;
   localparam int FRAME_WIDTH_W = 10;
   localparam int FRAME_HGT_W   = 12;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 12;

   localparam int DEFAULT_MAX_WIDTH = 512;

   localparam logic [FRAME_WIDTH_W-1:0] FRAME_WIDTH_RESET  = FRAME_WIDTH_W'(512);
   localparam logic [FRAME_HGT_W-1:0]   FRAME_HEIGHT_RESET = FRAME_HGT_W'(512);

   localparam int unsigned EMBOSS_OFFSET = 128;
   localparam int unsigned CHANNEL_MAX   = 255;

   // Result queue between the compute stage and the response channel.
   localparam int FIFO_DEPTH = 8;
   localparam int FPTR_W     = $clog2(FIFO_DEPTH);
   localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      rgb_type              pix;
      logic [ROW_W-1:0]     row;
      logic [COL_OUT_W-1:0] col;
      logic                 last;
   } result_type;

   // |below - above| + offset, saturated to the channel range.
   function automatic logic [CHAN_W-1:0] emboss_channel(input logic [CHAN_W-1:0] below,
                                                        input logic [CHAN_W-1:0] above);
      logic [CHAN_W-1:0] diff;
      logic [CHAN_W:0]   sum;
      diff = (below >= above) ? (below - above) : (above - below);
      sum  = {1'b0, diff} + (CHAN_W + 1)'(EMBOSS_OFFSET);
      return (sum > (CHAN_W + 1)'(CHANNEL_MAX)) ? CHAN_W'(CHANNEL_MAX) : sum[CHAN_W-1:0];
   endfunction

   function automatic rgb_type emboss_pixel(input rgb_type below, input rgb_type above);
      rgb_type res;
      res.red   = emboss_channel(below.red, above.red);
      res.green = emboss_channel(below.green, above.green);
      res.blue  = emboss_channel(below.blue, above.blue);
      return res;
   endfunction

endpackage

[rtl/vef_intf.sv]
// ----------------------------------------------------------------------------
// vef_intf: channel interfaces of the vertical emboss filter
//
// Pixel request channel, result response channel and register write channel,
// each a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface vef_req_if;
   logic                      valid;
   logic                      ready;
   logic [vef_pkg::CHAN_W-1:0] in_red;
   logic [vef_pkg::CHAN_W-1:0] in_green;
   logic [vef_pkg::CHAN_W-1:0] in_blue;

   modport source (output valid, output in_red, output in_green, output in_blue,
                   input ready);
   modport sink   (input valid, input in_red, input in_green, input in_blue,
                   output ready);
endinterface

interface vef_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [vef_pkg::CHAN_W-1:0]    out_red;
   logic [vef_pkg::CHAN_W-1:0]    out_green;
   logic [vef_pkg::CHAN_W-1:0]    out_blue;
   logic [vef_pkg::ROW_W-1:0]     out_row;
   logic [vef_pkg::COL_OUT_W-1:0] out_col;
   logic                          last_of_run;

   modport source (output valid, output out_red, output out_green, output out_blue,
                   output out_row, output out_col, output last_of_run, input ready);
   modport sink   (input valid, input out_red, input out_green, input out_blue,
                   input out_row, input out_col, input last_of_run, output ready);
endinterface

interface vef_csr_if;
   logic                           valid;
   logic                           ready;
   logic [vef_pkg::CSR_INDEX_W-1:0] index;
   logic [vef_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/vef_ram.sv]
// ----------------------------------------------------------------------------
// vef_ram: simple dual-port RAM with registered read
//
// One write port and one read port; a read of the address being written in
// the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module vef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/vertical_emboss_filter.sv]
// ----------------------------------------------------------------------------
// vertical_emboss_filter: vertical emboss over an RGB raster stream
//
// Pixels enter on req_chan in raster order; the block keeps its own row and
// column count. Results leave on rsp_chan with their row and column. A pixel
// of row r gives the result for row r-1 at the same column (row 0 unchanged,
// inner rows as |below - above| + 128 saturated at 255); a pixel of the last
// row also gives itself unchanged, and last_of_run marks the final result of
// each request. Pixels of row 0 give nothing, unless the frame has one row.
// Throughput: one request per clock while the result queue has room. On the
// last row each request gives two results, so there the response channel sets
// the pace. A taken request is registered in the compute stage, and its
// results are then written into the queue, from which they are offered.
// The two line buffers share one RAM word per column, read when the request
// is taken and written back in the next cycle; a same-column back-to-back pair
// (width 1) is forwarded. Results queue in an 8-entry buffer; requests are
// held off while that buffer lacks room, so a stalled receiver stops intake.
// Reset clears the counters and the queue and sets width and height to 512.
// Writes on csr_chan are taken at any time and restart the frame at row 0,
// column 0; they are to be issued while the block is idle.
// ----------------------------------------------------------------------------
module vertical_emboss_filter #(
   parameter int MAX_WIDTH = vef_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic      clock,
   input  logic      reset,
   vef_req_if.sink   req_chan,
   vef_rsp_if.source rsp_chan,
   vef_csr_if.sink   csr_chan
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
   localparam int RAM_W  = 2 * vef_pkg::RGB_W;
   localparam int ROW_W  = vef_pkg::ROW_W;

   // ---------------------------------------------------------------- registers
   logic [vef_pkg::FRAME_WIDTH_W-1:0] frame_width_ff, frame_width_in;
   logic [vef_pkg::FRAME_HGT_W-1:0]   frame_height_ff, frame_height_in;
   logic                              csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write) begin
         unique case (csr_chan.index)
            vef_pkg::CSR_FRAME_WIDTH:
               frame_width_in = csr_chan.data[vef_pkg::FRAME_WIDTH_W-1:0];
            vef_pkg::CSR_FRAME_HEIGHT:
               frame_height_in = csr_chan.data[vef_pkg::FRAME_HGT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= vef_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= vef_pkg::FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   logic [WCNT_W-1:0] eff_width;
   logic [ROW_W-1:0]  eff_height;

   always_comb begin
      if (frame_width_ff == '0) begin
         eff_width = WCNT_W'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         eff_width = WCNT_W'(MAX_WIDTH);
      end else begin
         eff_width = WCNT_W'(frame_width_ff);
      end
      eff_height = (frame_height_ff == '0) ? ROW_W'(1) : frame_height_ff;
   end

   // ---------------------------------------------------------------- counters
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [WCNT_W-1:0] col_inc;
   logic [ROW_W-1:0]  row_inc;
   logic              req_accept;
   logic              last_row;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign last_row   = (row_ff == eff_height - ROW_W'(1));
   assign col_inc    = WCNT_W'(col_ff) + WCNT_W'(1);
   assign row_inc    = row_ff + ROW_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (col_inc >= eff_width) begin
            col_in = '0;
            row_in = last_row ? '0 : row_inc;
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------ line buffers
   // Each word holds {row r-2, row r-1} of one column.
   logic             wr_en;
   logic [COL_W-1:0] wr_addr;
   logic [RAM_W-1:0] wr_data;
   logic [RAM_W-1:0] rd_data;

   vef_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   // ----------------------------------------------------------- compute stage
   logic                s1_valid_ff;
   vef_pkg::rgb_type    s1_pix_ff;
   logic [ROW_W-1:0]    s1_row_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic                s1_last_row_ff;
   logic                fwd_hit_ff, fwd_hit_in;
   logic [RAM_W-1:0]    fwd_data_ff;
   logic [RAM_W-1:0]    line_word;
   vef_pkg::rgb_type    older_pix;
   vef_pkg::rgb_type    prev_pix;

   // The RAM read taken with this request missed the write-back of the
   // request just ahead when both hit the same column.
   assign line_word = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign older_pix = line_word[RAM_W-1:vef_pkg::RGB_W];
   assign prev_pix  = line_word[vef_pkg::RGB_W-1:0];

   assign wr_en      = s1_valid_ff;
   assign wr_addr    = s1_col_ff;
   assign wr_data    = {prev_pix, s1_pix_ff};
   assign fwd_hit_in = s1_valid_ff && req_accept && (s1_col_ff == col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
         fwd_hit_ff  <= fwd_hit_in;
      end
      if (req_accept) begin
         s1_pix_ff      <= {req_chan.in_red, req_chan.in_green, req_chan.in_blue};
         s1_row_ff      <= row_ff;
         s1_col_ff      <= col_ff;
         s1_last_row_ff <= last_row;
      end
      fwd_data_ff <= wr_data;
   end

   vef_pkg::result_type res_above;
   vef_pkg::result_type res_self;
   vef_pkg::result_type slot_a;
   logic                has_above;
   logic [1:0]          push_n;

   always_comb begin
      has_above      = (s1_row_ff != '0);
      res_above.pix  = (s1_row_ff == ROW_W'(1)) ? prev_pix
                                                : vef_pkg::emboss_pixel(s1_pix_ff, older_pix);
      res_above.row  = s1_row_ff - ROW_W'(1);
      res_above.col  = vef_pkg::COL_OUT_W'(s1_col_ff);
      res_above.last = !s1_last_row_ff;
      res_self.pix   = s1_pix_ff;
      res_self.row   = s1_row_ff;
      res_self.col   = vef_pkg::COL_OUT_W'(s1_col_ff);
      res_self.last  = 1'b1;
      slot_a         = has_above ? res_above : res_self;
      push_n         = s1_valid_ff ? (2'(has_above) + 2'(s1_last_row_ff)) : 2'd0;
   end

   // ------------------------------------------------------------ result queue
   vef_pkg::result_type             fifo_mem [vef_pkg::FIFO_DEPTH];
   logic [vef_pkg::FPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [vef_pkg::FPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [vef_pkg::FCNT_W-1:0]      count_ff, count_in;
   logic [vef_pkg::FCNT_W:0]        reserved;
   logic                            rsp_pop;
   vef_pkg::result_type             head;

   assign rsp_pop  = rsp_chan.valid && rsp_chan.ready;
   assign reserved = (vef_pkg::FCNT_W + 1)'(count_ff)
                   + (vef_pkg::FCNT_W + 1)'({s1_valid_ff, 1'b0});

   // Room for the stage ahead plus the two results this request may give.
   assign req_chan.ready = (reserved <= (vef_pkg::FCNT_W + 1)'(vef_pkg::FIFO_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + vef_pkg::FPTR_W'(push_n);
      rd_ptr_in = rsp_pop ? (rd_ptr_ff + vef_pkg::FPTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff + vef_pkg::FCNT_W'(push_n) - vef_pkg::FCNT_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_n != 2'd0) begin
         fifo_mem[wr_ptr_ff] <= slot_a;
      end
      if (push_n == 2'd2) begin
         fifo_mem[wr_ptr_ff + vef_pkg::FPTR_W'(1)] <= res_self;
      end
   end

   assign head                 = fifo_mem[rd_ptr_ff];
   assign rsp_chan.valid       = (count_ff != '0);
   assign rsp_chan.out_red     = head.pix.red;
   assign rsp_chan.out_green   = head.pix.green;
   assign rsp_chan.out_blue    = head.pix.blue;
   assign rsp_chan.out_row     = head.row;
   assign rsp_chan.out_col     = head.col;
   assign rsp_chan.last_of_run = head.last;

   // -------------------------------------------------------------- assertions
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= vef_pkg::FCNT_W'(vef_pkg::FIFO_DEPTH))
      else $error("result queue holds more than its depth");

   a_fwd_needs_stage: assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> s1_valid_ff && ($past(col_ff) == s1_col_ff))
      else $error("forwarded line word without a matching request in the stage");

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      WCNT_W'(col_ff) < eff_width)
      else $error("column count outside the frame width");

   a_csr_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (col_ff == '0) && (row_ff == '0))
      else $error("register write did not restart the frame");

   a_no_push_when_idle: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |=> (count_ff <= $past(count_ff)))
      else $error("result queue grew without a request in the stage");

endmodule
